[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DMWC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dmwc assertion failed");
`define DMWC_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("dmwc forbidden condition seen");
`else
`define DMWC_ASSERT(label, clk, rst_n, prop)
`define DMWC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[hw/rtl/dmwc_pkg.sv]
// ----------------------------------------------------------------------------
// dmwc_pkg
// Types and codes shared by the direct-mapped write-back cache modules.
// ----------------------------------------------------------------------------
package dmwc_pkg;

  localparam int unsigned FwordW = 4;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STORE = 2'd1,
    OP_FILL  = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_LOAD_DATA  = 3'd0,
    KIND_STORE_DONE = 3'd1,
    KIND_WRITEBACK  = 3'd2,
    KIND_FILL_REQ   = 3'd3,
    KIND_FLUSH_DONE = 3'd4,
    KIND_ERROR      = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CMD_ERR        = 3'd0,
    CMD_FLUSH_DONE = 3'd1,
    CMD_FIN        = 3'd2,
    CMD_MISS       = 3'd3,
    CMD_FILL       = 3'd4,
    CMD_WB_LINE    = 3'd5
  } cmd_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] addr;
    logic [31:0] store_data;
    logic [31:0] fill_data;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] mem_addr;
    logic [31:0] data;
    logic        was_hit;
    logic        last;
    logic [31:0] hits_so_far;
    logic [31:0] misses_so_far;
  } out_t;

  // Work handed from the classifier to the execution engine.
  typedef struct packed {
    cmd_e              kind;
    logic              store;
    logic              hit;
    logic              last;
    logic              fin;
    logic              wb;
    logic [31:0]       addr;
    logic [31:0]       wb_base;
    logic [31:0]       store_data;
    logic [31:0]       fill_data;
    logic [FwordW-1:0] fword;
    logic [31:0]       hits;
    logic [31:0]       misses;
  } cmd_t;

endpackage

[hw/rtl/direct_mapped_writeback_cache.sv]
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct-mapped, write-back, write-allocate data cache with a classifier
// front end, a two-entry command queue and an execution engine.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low: busy_o rises
// while the two-entry command queue is full or a flush is walking the sets
// (one set per cycle while the queue has room). Results appear on res_o for
// exactly one cycle with res_valid_o and cannot be held off. The execution
// engine sets the pace: it takes a new command only once the last is done.
// A miss writes back a dirty victim word by word before its fill request,
// as a flush does for each dirty line; the last fill word completes the access.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache #(
  parameter int unsigned NUM_SETS   = 16,
  parameter int unsigned LINE_BYTES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  dmwc_pkg::in_t   item_i,
  output logic            res_valid_o,
  output dmwc_pkg::out_t  res_o
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  dmwc_pkg::cmd_t cmd_in;
  dmwc_pkg::cmd_t cmd_out;

  dmwc_front #(
    .NUM_SETS   (NUM_SETS),
    .LINE_BYTES (LINE_BYTES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .item_i (item_i),
    .full_i (full),
    .busy_o (busy_o),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  dmwc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .cmd_o  (cmd_out)
  );

  dmwc_back #(
    .NUM_SETS   (NUM_SETS),
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .cmd_i      (cmd_out),
    .pop_o      (pop),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

[hw/rtl/dmwc_fifo.sv]
// ----------------------------------------------------------------------------
// dmwc_fifo
// Two-entry command queue between the classifier and the execution engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmwc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dmwc_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output dmwc_pkg::cmd_t  cmd_o
);

  dmwc_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  `DMWC_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o && !pop_i)
  `DMWC_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)

endmodule

[hw/rtl/dmwc_front.sv]
// ----------------------------------------------------------------------------
// dmwc_front
// Accepts items, looks up tags, keeps line state and counters, and queues
// commands for the execution engine. Walks the sets during a flush.
// ----------------------------------------------------------------------------
module dmwc_front #(
  parameter int unsigned NUM_SETS   = 16,
  parameter int unsigned LINE_BYTES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  dmwc_pkg::in_t   item_i,
  input  logic            full_i,
  output logic            busy_o,
  output logic            push_o,
  output dmwc_pkg::cmd_t  cmd_o
);

  localparam int unsigned OffBits  = $clog2(LINE_BYTES);
  localparam int unsigned IdxBits  = $clog2(NUM_SETS);
  localparam int unsigned TagBits  = 32 - OffBits - IdxBits;
  localparam int unsigned WordBits = OffBits - 2;
  localparam int unsigned Wpl      = LINE_BYTES / 4;
  localparam int unsigned MaxLines = 64 / Wpl;
  localparam int unsigned LineCntW = $clog2(MaxLines + 1);

  typedef enum logic [1:0] {
    FE_RUN   = 2'b01,
    FE_FLUSH = 2'b10
  } fe_state_e;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_LOAD  = 2'd1,
    PEND_STORE = 2'd2
  } pend_e;

  fe_state_e             state_q, state_d;
  pend_e                 pend_q, pend_d;
  logic [NUM_SETS-1:0]   valid_q, valid_d;
  logic [NUM_SETS-1:0]   dirty_q, dirty_d;
  logic [TagBits-1:0]    tag_q [NUM_SETS];
  logic                  tag_we;
  logic [31:0]           hits_q, hits_d;
  logic [31:0]           misses_q, misses_d;
  logic [31:0]           pend_addr_q, pend_addr_d;
  logic [31:0]           pend_store_q, pend_store_d;
  logic [WordBits-1:0]   fill_cnt_q, fill_cnt_d;
  logic [IdxBits-1:0]    scan_q, scan_d;
  logic [LineCntW-1:0]   nlines_q, nlines_d;

  logic                  acc;
  logic [IdxBits-1:0]    set_a;
  logic [IdxBits-1:0]    pset;
  logic [TagBits-1:0]    tag_a;
  logic                  hit;
  logic [NUM_SETS-1:0]   above;
  logic                  flast;

  assign busy_o = full_i || (state_q != FE_RUN);
  assign acc    = start_i && !busy_o;
  assign set_a  = item_i.addr[OffBits +: IdxBits];
  assign tag_a  = item_i.addr[31 -: TagBits];
  assign pset   = pend_addr_q[OffBits +: IdxBits];
  assign hit    = valid_q[set_a] && (tag_q[set_a] == tag_a);

  always_comb begin
    for (int i = 0; i < NUM_SETS; i++) begin
      above[i] = (i > int'(scan_q));
    end
  end

  // Last line of a flush: budget used up or nothing dirty further on.
  assign flast = (nlines_q == LineCntW'(MaxLines - 1)) || !(|(dirty_q & above));

  always_comb begin
    state_d      = state_q;
    pend_d       = pend_q;
    valid_d      = valid_q;
    dirty_d      = dirty_q;
    hits_d       = hits_q;
    misses_d     = misses_q;
    pend_addr_d  = pend_addr_q;
    pend_store_d = pend_store_q;
    fill_cnt_d   = fill_cnt_q;
    scan_d       = scan_q;
    nlines_d     = nlines_q;
    tag_we       = 1'b0;
    push_o       = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      FE_RUN: begin
        if (acc) begin
          if (item_i.op == dmwc_pkg::OP_FILL) begin
            if (pend_q != PEND_NONE) begin
              push_o           = 1'b1;
              cmd_o.kind       = dmwc_pkg::CMD_FILL;
              cmd_o.addr       = pend_addr_q;
              cmd_o.store      = (pend_q == PEND_STORE);
              cmd_o.store_data = pend_store_q;
              cmd_o.fill_data  = item_i.fill_data;
              cmd_o.fword      = dmwc_pkg::FwordW'(fill_cnt_q);
              if (fill_cnt_q == WordBits'(Wpl - 1)) begin
                cmd_o.fin     = 1'b1;
                valid_d[pset] = 1'b1;
                if (pend_q == PEND_STORE) begin
                  dirty_d[pset] = 1'b1;
                end
                pend_d     = PEND_NONE;
                fill_cnt_d = '0;
              end else begin
                fill_cnt_d = fill_cnt_q + WordBits'(1);
              end
            end
          end else if (pend_q != PEND_NONE) begin
            push_o     = 1'b1;
            cmd_o.kind = dmwc_pkg::CMD_ERR;
          end else if (item_i.op == dmwc_pkg::OP_FLUSH) begin
            if (|dirty_q) begin
              state_d  = FE_FLUSH;
              scan_d   = '0;
              nlines_d = '0;
            end else begin
              push_o     = 1'b1;
              cmd_o.kind = dmwc_pkg::CMD_FLUSH_DONE;
            end
          end else if (item_i.addr[1:0] != 2'b00) begin
            push_o     = 1'b1;
            cmd_o.kind = dmwc_pkg::CMD_ERR;
          end else if (hit) begin
            hits_d           = hits_q + 32'd1;
            push_o           = 1'b1;
            cmd_o.kind       = dmwc_pkg::CMD_FIN;
            cmd_o.hit        = 1'b1;
            cmd_o.store      = (item_i.op == dmwc_pkg::OP_STORE);
            cmd_o.addr       = item_i.addr;
            cmd_o.store_data = item_i.store_data;
            if (item_i.op == dmwc_pkg::OP_STORE) begin
              dirty_d[set_a] = 1'b1;
            end
          end else begin
            misses_d       = misses_q + 32'd1;
            push_o         = 1'b1;
            cmd_o.kind     = dmwc_pkg::CMD_MISS;
            cmd_o.wb       = valid_q[set_a] && dirty_q[set_a];
            cmd_o.wb_base  = {tag_q[set_a], set_a, OffBits'(0)};
            cmd_o.addr     = item_i.addr;
            valid_d[set_a] = 1'b0;
            dirty_d[set_a] = 1'b0;
            tag_we         = 1'b1;
            pend_d         = (item_i.op == dmwc_pkg::OP_STORE) ? PEND_STORE : PEND_LOAD;
            pend_addr_d    = item_i.addr;
            pend_store_d   = item_i.store_data;
            fill_cnt_d     = '0;
          end
        end
      end
      FE_FLUSH: begin
        if (!full_i) begin
          if (dirty_q[scan_q]) begin
            push_o          = 1'b1;
            cmd_o.kind      = dmwc_pkg::CMD_WB_LINE;
            cmd_o.wb_base   = {tag_q[scan_q], scan_q, OffBits'(0)};
            cmd_o.last      = flast;
            dirty_d[scan_q] = 1'b0;
            nlines_d        = nlines_q + LineCntW'(1);
          end
          if ((dirty_q[scan_q] && flast) || (scan_q == IdxBits'(NUM_SETS - 1))) begin
            state_d = FE_RUN;
          end else begin
            scan_d = scan_q + IdxBits'(1);
          end
        end
      end
      default: state_d = FE_RUN;
    endcase
    cmd_o.hits   = hits_d;
    cmd_o.misses = misses_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FE_RUN;
      pend_q       <= PEND_NONE;
      valid_q      <= '0;
      dirty_q      <= '0;
      hits_q       <= '0;
      misses_q     <= '0;
      pend_addr_q  <= '0;
      pend_store_q <= '0;
      fill_cnt_q   <= '0;
      scan_q       <= '0;
      nlines_q     <= '0;
    end else begin
      state_q      <= state_d;
      pend_q       <= pend_d;
      valid_q      <= valid_d;
      dirty_q      <= dirty_d;
      hits_q       <= hits_d;
      misses_q     <= misses_d;
      pend_addr_q  <= pend_addr_d;
      pend_store_q <= pend_store_d;
      fill_cnt_q   <= fill_cnt_d;
      scan_q       <= scan_d;
      nlines_q     <= nlines_d;
    end
  end

  // Tags are only read under a valid or dirty bit, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_q[set_a] <= tag_a;
    end
  end

endmodule

[hw/rtl/dmwc_back.sv]
// ----------------------------------------------------------------------------
// dmwc_back
// Execution engine: owns the line data memory, carries out queued commands
// and drives one result per cycle at most.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmwc_back #(
  parameter int unsigned NUM_SETS   = 16,
  parameter int unsigned LINE_BYTES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  dmwc_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  output logic            res_valid_o,
  output dmwc_pkg::out_t  res_o
);

  localparam int unsigned OffBits  = $clog2(LINE_BYTES);
  localparam int unsigned IdxBits  = $clog2(NUM_SETS);
  localparam int unsigned WordBits = OffBits - 2;
  localparam int unsigned Wpl      = LINE_BYTES / 4;
  localparam int unsigned Depth    = NUM_SETS * Wpl;
  localparam int unsigned MemAw    = IdxBits + WordBits;

  typedef enum logic [4:0] {
    BE_IDLE = 5'b00001,
    BE_RUN  = 5'b00010,
    BE_WB   = 5'b00100,
    BE_FREQ = 5'b01000,
    BE_FIN  = 5'b10000
  } be_state_e;

  be_state_e           state_q, state_d;
  dmwc_pkg::cmd_t      cur_q, cur_d;
  logic [WordBits-1:0] cnt_q, cnt_d;
  logic                res_valid_q, res_valid_d;
  dmwc_pkg::out_t      res_q, res_d;

  logic [31:0]         mem_q [Depth];
  logic [31:0]         rdata_q;
  logic                we;
  logic [MemAw-1:0]    waddr;
  logic [31:0]         wdata;
  logic [MemAw-1:0]    raddr;
  logic                wb_end;

  assign pop_o       = (state_q == BE_IDLE) && !empty_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign wb_end      = (cnt_q == WordBits'(Wpl - 1));

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.hits_so_far   = cur_q.hits;
    res_d.misses_so_far = cur_q.misses;
    we    = 1'b0;
    waddr = {cur_q.addr[OffBits +: IdxBits], cur_q.addr[2 +: WordBits]};
    wdata = cur_q.store_data;
    raddr = {cur_q.addr[OffBits +: IdxBits], cur_q.addr[2 +: WordBits]};
    unique case (state_q)
      BE_IDLE: begin
        if (pop_o) begin
          cur_d   = cmd_i;
          cnt_d   = '0;
          state_d = BE_RUN;
        end
      end
      BE_RUN: begin
        unique case (cur_q.kind)
          dmwc_pkg::CMD_ERR: begin
            res_valid_d = 1'b1;
            res_d.kind  = dmwc_pkg::KIND_ERROR;
            res_d.last  = 1'b1;
            state_d     = BE_IDLE;
          end
          dmwc_pkg::CMD_FLUSH_DONE: begin
            res_valid_d = 1'b1;
            res_d.kind  = dmwc_pkg::KIND_FLUSH_DONE;
            res_d.last  = 1'b1;
            state_d     = BE_IDLE;
          end
          dmwc_pkg::CMD_FIN: begin
            if (cur_q.store) begin
              we            = 1'b1;
              res_valid_d   = 1'b1;
              res_d.kind    = dmwc_pkg::KIND_STORE_DONE;
              res_d.was_hit = cur_q.hit;
              res_d.last    = 1'b1;
              state_d       = BE_IDLE;
            end else begin
              state_d = BE_FIN;
            end
          end
          dmwc_pkg::CMD_FILL: begin
            we    = 1'b1;
            waddr = {cur_q.addr[OffBits +: IdxBits], cur_q.fword[WordBits-1:0]};
            wdata = cur_q.fill_data;
            // Last fill word: the command becomes a finish command for the waiting access.
            if (cur_q.fin) begin
              cur_d.kind = dmwc_pkg::CMD_FIN;
            end else begin
              state_d = BE_IDLE;
            end
          end
          dmwc_pkg::CMD_MISS: begin
            raddr   = {cur_q.wb_base[OffBits +: IdxBits], WordBits'(0)};
            state_d = cur_q.wb ? BE_WB : BE_FREQ;
          end
          dmwc_pkg::CMD_WB_LINE: begin
            raddr   = {cur_q.wb_base[OffBits +: IdxBits], WordBits'(0)};
            state_d = BE_WB;
          end
          default: state_d = BE_IDLE;
        endcase
      end
      BE_WB: begin
        res_valid_d    = 1'b1;
        res_d.kind     = dmwc_pkg::KIND_WRITEBACK;
        res_d.mem_addr = {cur_q.wb_base[31:OffBits], cnt_q, 2'b00};
        res_d.data     = rdata_q;
        res_d.last     = wb_end && (cur_q.kind == dmwc_pkg::CMD_WB_LINE) && cur_q.last;
        raddr          = {cur_q.wb_base[OffBits +: IdxBits], cnt_q + WordBits'(1)};
        cnt_d          = cnt_q + WordBits'(1);
        if (wb_end) begin
          state_d = (cur_q.kind == dmwc_pkg::CMD_MISS) ? BE_FREQ : BE_IDLE;
        end
      end
      BE_FREQ: begin
        res_valid_d    = 1'b1;
        res_d.kind     = dmwc_pkg::KIND_FILL_REQ;
        res_d.mem_addr = {cur_q.addr[31:OffBits], OffBits'(0)};
        res_d.last     = 1'b1;
        state_d        = BE_IDLE;
      end
      BE_FIN: begin
        res_valid_d   = 1'b1;
        res_d.kind    = dmwc_pkg::KIND_LOAD_DATA;
        res_d.data    = rdata_q;
        res_d.was_hit = cur_q.hit;
        res_d.last    = 1'b1;
        state_d       = BE_IDLE;
      end
      default: state_d = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  // Line data: lines are always filled before their data is used.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  `DMWC_ASSERT(a_pop_starts_run, clk_i, rst_ni, pop_o |=> state_q == BE_RUN)
  `DMWC_ASSERT(a_result_from_work, clk_i, rst_ni, res_valid_q |-> $past(state_q) != BE_IDLE)

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Direct-mapped write-back cache regression
// Drives loads, stores, fill words and flushes through the command handshake.
// Every result is checked, field by field and in order, against a cache model
// kept in the testbench. Sender gaps are varied across several phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NSETS = 16;
  localparam int unsigned WPL   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  // Cache model and the store of expected results.
  class cache_scoreboard;
    bit              valid [NSETS];
    bit              dirty [NSETS];
    bit [23:0]       tag   [NSETS];
    bit [31:0]       words [NSETS*WPL];
    bit [31:0]       hits, misses;
    bit [1:0]        wait_op;  // 0 none, 1 load, 2 store
    bit [31:0]       wait_addr, wait_store;
    int unsigned     fill_idx;
    dmwc_pkg::out_t  expected_q[$];
    int              errors;

    function void push(dmwc_pkg::kind_e k, bit [31:0] ma, bit [31:0] d, bit h, bit l);
      dmwc_pkg::out_t r;
      r.kind = k; r.mem_addr = ma; r.data = d; r.was_hit = h; r.last = l;
      r.hits_so_far = hits; r.misses_so_far = misses;
      expected_q.push_back(r);
    endfunction

    function void write_line(int unsigned s, bit fin);
      bit [31:0] base;
      base = {tag[s], s[3:0], 4'b0000};
      for (int unsigned w = 0; w < WPL; w++)
        push(dmwc_pkg::KIND_WRITEBACK, base + 4*w, words[s*WPL+w], 1'b0,
             fin && w == WPL-1);
    endfunction

    function void complete(bit st, bit [31:0] a, bit [31:0] sd, bit h);
      int unsigned s, i;
      s = a[7:4];
      i = s*WPL + a[3:2];
      if (st) begin
        words[i] = sd;
        dirty[s] = 1'b1;
        push(dmwc_pkg::KIND_STORE_DONE, '0, '0, h, 1'b1);
      end else begin
        push(dmwc_pkg::KIND_LOAD_DATA, '0, words[i], h, 1'b1);
      end
    endfunction

    function void note_item(dmwc_pkg::in_t it);
      int unsigned s, lastset;
      bit any;
      if (it.op == dmwc_pkg::OP_FILL) begin
        if (wait_op == 0) return;
        s = wait_addr[7:4];
        words[s*WPL+fill_idx] = it.fill_data;
        fill_idx++;
        if (fill_idx == WPL) begin
          valid[s] = 1'b1;
          fill_idx = 0;
          complete(wait_op == 2, wait_addr, wait_store, 1'b0);
          wait_op = 0;
        end
        return;
      end
      if (wait_op != 0) begin
        push(dmwc_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b1);
        return;
      end
      if (it.op == dmwc_pkg::OP_FLUSH) begin
        any = 1'b0;
        lastset = 0;
        for (int unsigned k = 0; k < NSETS; k++)
          if (dirty[k]) begin any = 1'b1; lastset = k; end
        if (!any) begin
          push(dmwc_pkg::KIND_FLUSH_DONE, '0, '0, 1'b0, 1'b1);
          return;
        end
        for (int unsigned k = 0; k <= lastset; k++)
          if (dirty[k]) begin
            write_line(k, k == lastset);
            dirty[k] = 1'b0;
          end
        return;
      end
      if (it.addr[1:0] != 2'b00) begin
        push(dmwc_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b1);
        return;
      end
      s = it.addr[7:4];
      if (valid[s] && tag[s] == it.addr[31:8]) begin
        hits++;
        complete(it.op == dmwc_pkg::OP_STORE, it.addr, it.store_data, 1'b1);
        return;
      end
      misses++;
      if (valid[s] && dirty[s]) write_line(s, 1'b0);
      valid[s] = 1'b0;
      dirty[s] = 1'b0;
      tag[s] = it.addr[31:8];
      wait_op = (it.op == dmwc_pkg::OP_STORE) ? 2 : 1;
      wait_addr = it.addr;
      wait_store = it.store_data;
      fill_idx = 0;
      push(dmwc_pkg::KIND_FILL_REQ, {it.addr[31:4], 4'b0000}, '0, 1'b0, 1'b1);
    endfunction

    function void check_result(dmwc_pkg::out_t got);
      dmwc_pkg::out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d", got.kind);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.kind != e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, got.kind); errors++;
      end
      if (got.mem_addr != e.mem_addr) begin
        $error("mem_addr: expected %h, actual %h", e.mem_addr, got.mem_addr); errors++;
      end
      if (got.data != e.data) begin
        $error("data: expected %h, actual %h", e.data, got.data); errors++;
      end
      if (got.was_hit != e.was_hit) begin
        $error("was_hit: expected %0d, actual %0d", e.was_hit, got.was_hit); errors++;
      end
      if (got.last != e.last) begin
        $error("last: expected %0d, actual %0d", e.last, got.last); errors++;
      end
      if (got.hits_so_far != e.hits_so_far) begin
        $error("hits_so_far: expected %0d, actual %0d", e.hits_so_far,
               got.hits_so_far);
        errors++;
      end
      if (got.misses_so_far != e.misses_so_far) begin
        $error("misses_so_far: expected %0d, actual %0d", e.misses_so_far,
               got.misses_so_far);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, res_valid_o;
  dmwc_pkg::in_t  item_i = '0;
  dmwc_pkg::out_t res_o;

  cache_scoreboard sb = new();
  int unsigned idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned phase_pct[4] = '{0, 68, 0, 23};
  // Tags kept few so that random accesses hit, conflict and evict often.
  bit [23:0] tag_pool[4] = '{24'h000000, 24'hFFFFFF, 24'h5A5A5A, 24'hA5A5A5};

  direct_mapped_writeback_cache uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .item_i(item_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  always #5 clk_i = ~clk_i;

  // Sample mid-cycle: ports are steady from here to the accepting edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) sb.check_result(res_o);
      if ((start_i && !busy_o) || res_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("direct_mapped_writeback_cache regression: fail");
        $finish;
      end
    end
  end

  // Hand one item over; start stays high across back-to-back items.
  task automatic send_item(dmwc_pkg::in_t it);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic send_op(dmwc_pkg::op_e op, bit [31:0] a, bit [31:0] sd, bit [31:0] fd);
    dmwc_pkg::in_t it;
    it.op = op; it.addr = a; it.store_data = sd; it.fill_data = fd;
    send_item(it);
  endtask

  task automatic send_fills();
    for (int k = 0; k < WPL; k++) send_op(dmwc_pkg::OP_FILL, $urandom, $urandom, $urandom);
  endtask

  function automatic bit [31:0] rand_addr();
    return {tag_pool[$urandom_range(3)], 4'($urandom), 2'($urandom), 2'b00};
  endfunction

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      send_op($urandom_range(1) ? dmwc_pkg::OP_STORE : dmwc_pkg::OP_LOAD, rand_addr(),
              $urandom, $urandom);
      if (sb.wait_op != 0) send_fills();
    end else if (r < 78) send_op(dmwc_pkg::OP_FLUSH, $urandom, $urandom, $urandom);
    else if (r < 86) send_op(dmwc_pkg::OP_FILL, $urandom, $urandom, $urandom);
    else if (r < 93) send_op(dmwc_pkg::op_e'($urandom_range(1)), $urandom | 32'h1,
                             $urandom, 0);
    else begin
      // Broken sequence: an access or a flush while the fill is outstanding.
      send_op(dmwc_pkg::OP_LOAD, rand_addr(), $urandom, $urandom);
      if (sb.wait_op != 0) begin
        send_op(dmwc_pkg::op_e'($urandom_range(1) ? 3 : $urandom_range(1)),
                $urandom & ~32'h3, $urandom, $urandom);
        send_fills();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty flush, stray fill, both misaligned forms, extreme addresses.
    send_op(dmwc_pkg::OP_FLUSH, '0, '0, '0);
    send_op(dmwc_pkg::OP_FILL, '0, '0, 32'hFFFF_FFFF);
    send_op(dmwc_pkg::OP_LOAD, 32'h0000_0001, '0, '0);
    send_op(dmwc_pkg::OP_STORE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, '0);
    send_op(dmwc_pkg::OP_STORE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, '0);
    send_op(dmwc_pkg::OP_LOAD, 32'h0000_0000, '0, '0);  // error: fill outstanding
    send_op(dmwc_pkg::OP_FLUSH, '0, '0, '0);            // error: fill outstanding
    send_fills();
    send_op(dmwc_pkg::OP_LOAD, 32'hFFFF_FFFC, '0, '0);
    send_op(dmwc_pkg::OP_STORE, 32'hFFFF_FFF0, 32'h0, '0);
    send_op(dmwc_pkg::OP_LOAD, 32'h0000_00F0, '0, '0);  // evicts the dirty line
    send_fills();
    send_op(dmwc_pkg::OP_STORE, 32'h0000_0000, 32'hA5A5_5A5A, '0);
    send_fills();
    send_op(dmwc_pkg::OP_FLUSH, '0, '0, '0);
    send_op(dmwc_pkg::OP_FLUSH, '0, '0, '0);

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      for (int n = 0; n < 16; n++) random_item();
    end
    start_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("direct_mapped_writeback_cache regression: pass");
    else
      $display("direct_mapped_writeback_cache regression: fail");
    $finish;
  end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/dmwc_pkg.sv
hw/rtl/dmwc_fifo.sv
hw/rtl/dmwc_front.sv
hw/rtl/dmwc_back.sv
hw/rtl/direct_mapped_writeback_cache.sv
test/tb.sv
